@@ hdl/lps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED pattern sequencer package
// Shared types, pattern codes, register indexes and the start pattern loader.
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int COUNT_W = 20;
    localparam int CFG_INDEX_W = 2;

    typedef logic [2:0] pattern_t;

    localparam pattern_t PAT_SOLID = 3'd0;
    localparam pattern_t PAT_BLINK = 3'd1;
    localparam pattern_t PAT_FASTER = 3'd2;
    localparam pattern_t PAT_TWINKLE = 3'd3;
    localparam pattern_t PAT_STAR = 3'd4;
    localparam pattern_t PAT_LIT = 3'd5;
    localparam pattern_t PAT_LOW = 3'd6;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_PATTERN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLEEP_TICK = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAKE_TICK = 2'd2;

    localparam logic [COUNT_W-1:0] SLEEP_TICK_RESET = 20'd115200;
    localparam logic [COUNT_W-1:0] WAKE_TICK_RESET = 20'd691200;

    localparam logic [9:0] DUTY_FULL = 10'd1023;
    localparam logic [9:0] DUTY_LIT = 10'd31;

    localparam logic [1:0] STEER_BOTH = 2'b11;
    localparam logic [1:0] STEER_B = 2'b10;
    localparam logic [1:0] STEER_A = 2'b01;

    localparam logic [1:0] LEDS_ON = 2'b11;
    localparam logic [1:0] LEDS_A = 2'b01;

    typedef struct packed {
        logic       table_sel;
        logic [1:0] steer;
        logic [9:0] value;
    } steer_duty_t;

    typedef struct packed {
        pattern_t     cur_pattern;
        pattern_t     saved_pattern;
        logic [COUNT_W-1:0] tick_count;
        logic         button_latched;
        logic [7:0]   twinkle_index;
        logic         pwm_running;
        logic [1:0]   led_levels;
        logic [1:0]   saved_led_levels;
        steer_duty_t  sd;
        steer_duty_t  saved_sd;
    } state_t;

    typedef struct packed {
        pattern_t   pattern;
        logic       led_a;
        logic       led_b;
        logic       pwm_enable;
        logic [1:0] pwm_steer;
        logic [9:0] pwm_duty;
        logic       duty_from_table;
        logic [7:0] table_index;
        logic       save_request;
    } result_t;

    function automatic state_t load_start(state_t s_in, logic [2:0] start);
        state_t   s;
        pattern_t p;
        s = s_in;
        p = (start > PAT_LIT) ? PAT_SOLID : start;
        s.cur_pattern = p;
        s.pwm_running = 1'b0;
        s.sd = '0;
        s.led_levels = (p == PAT_FASTER || p == PAT_STAR) ? LEDS_A : LEDS_ON;
        if (p >= PAT_TWINKLE)
        begin
            s.pwm_running = 1'b1;
            s.twinkle_index = '0;
            if (p == PAT_TWINKLE)
            begin
                s.sd = '{table_sel: 1'b0, steer: STEER_BOTH, value: DUTY_FULL};
            end
            else if (p == PAT_STAR)
            begin
                s.sd = '{table_sel: 1'b0, steer: STEER_B, value: DUTY_FULL};
            end
            else
            begin
                s.sd = '{table_sel: 1'b0, steer: STEER_A, value: DUTY_LIT};
            end
        end
        return s;
    endfunction

endpackage

@@ hdl/led_pattern_sequencer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED pattern sequencer
// Steps the LED pattern on each timer tick request and drives the LED and
// pwm controls.
//
// Each input request is one timer tick carrying the button level. It is
// taken into an input register, evaluated once the result register is free
// and held in the result register until the receiver takes it.
// One request is accepted every cycle while results are taken; the rate is
// set by the single state update per cycle in the tick logic.
// When the receiver stalls, the result register holds its request and the
// input register fills, after which in_ready drops until out_ready returns.
// The configuration channel is always ready. Writing start_pattern reloads
// the pattern, LED and pwm state; sleep_tick and wake_tick set the low power
// window of the tick counter. Reset loads the default start pattern (solid),
// the default sleep and wake counts and empties both registers. The duty
// table lies outside the block and is read at table_index.
// ----------------------------------------------------------------------------
module led_pattern_sequencer_top #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                button_down,
    output logic                                out_valid,
    input  logic                                out_ready,
    output lps_pkg::pattern_t                   pattern,
    output logic                                led_a,
    output logic                                led_b,
    output logic                                pwm_enable,
    output logic [1:0]                          pwm_steer,
    output logic [9:0]                          pwm_duty,
    output logic                                duty_from_table,
    output logic [7:0]                          table_index,
    output logic                                save_request,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lps_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lps_pkg::COUNT_W-1:0]         cfg_data
);
    import lps_pkg::*;

    localparam int MOD_W = $clog2(TABLE_DEPTH);

    logic               in_valid_reg;
    logic               button_reg;
    state_t             state_reg;
    state_t             state_next;
    state_t             state_loaded;
    logic [MOD_W-1:0]   mod_reg;
    logic [MOD_W-1:0]   mod_next;
    logic [COUNT_W-1:0] sleep_reg;
    logic [COUNT_W-1:0] wake_reg;
    result_t            step_result;
    result_t            out_result;
    logic               res_free;
    logic               step_en;
    logic               cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign step_en = in_valid_reg && res_free;
    assign in_ready = !in_valid_reg || step_en;
    assign state_loaded = load_start(state_reg, cfg_data[2:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            button_reg <= button_down;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{cur_pattern: PAT_SOLID, saved_pattern: PAT_SOLID,
                           tick_count: '0, button_latched: 1'b0, twinkle_index: '0,
                           pwm_running: 1'b0, led_levels: LEDS_ON,
                           saved_led_levels: '0, sd: '0, saved_sd: '0};
            mod_reg <= '0;
            sleep_reg <= SLEEP_TICK_RESET;
            wake_reg <= WAKE_TICK_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_START_PATTERN:
                begin
                    state_reg <= state_loaded;
                    if (state_loaded.twinkle_index == 8'd0)
                    begin
                        mod_reg <= '0;
                    end
                end
                CFG_SLEEP_TICK:
                begin
                    sleep_reg <= cfg_data;
                end
                CFG_WAKE_TICK:
                begin
                    wake_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
        else if (step_en)
        begin
            state_reg <= state_next;
            mod_reg <= mod_next;
        end
    end

    lps_step_logic #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_step (
        .state      (state_reg),
        .mod_index  (mod_reg),
        .button     (button_reg),
        .sleep_tick (sleep_reg),
        .wake_tick  (wake_reg),
        .state_next (state_next),
        .mod_next   (mod_next),
        .result     (step_result)
    );

    lps_result_reg u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step_en),
        .result     (step_result),
        .free       (res_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result)
    );

    assign pattern = out_result.pattern;
    assign led_a = out_result.led_a;
    assign led_b = out_result.led_b;
    assign pwm_enable = out_result.pwm_enable;
    assign pwm_steer = out_result.pwm_steer;
    assign pwm_duty = out_result.pwm_duty;
    assign duty_from_table = out_result.duty_from_table;
    assign table_index = out_result.table_index;
    assign save_request = out_result.save_request;

    // Low power always shows both LEDs dark.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pattern == PAT_LOW) |-> (!led_a && !led_b))
        else $error("LEDs lit in low power");

    // A save is never requested for the low power pattern.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && save_request) |-> (pattern != PAT_LOW))
        else $error("save requested in low power");

    // An evaluated tick always lands in the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> out_valid)
        else $error("evaluated tick produced no result");

    // The stored pattern never takes the unused code.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.cur_pattern != 3'd7 && state_reg.saved_pattern != 3'd7)
        else $error("pattern state holds an unused code");

endmodule

@@ hdl/lps_step_logic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED pattern sequencer tick logic
// Computes the next state and the result of one tick from the current state.
// ----------------------------------------------------------------------------
module lps_step_logic #(
    parameter int TABLE_DEPTH = 256
) (
    input  lps_pkg::state_t                      state,
    input  logic [$clog2(TABLE_DEPTH)-1:0]       mod_index,
    input  logic                                 button,
    input  logic [lps_pkg::COUNT_W-1:0]          sleep_tick,
    input  logic [lps_pkg::COUNT_W-1:0]          wake_tick,
    output lps_pkg::state_t                      state_next,
    output logic [$clog2(TABLE_DEPTH)-1:0]       mod_next,
    output lps_pkg::result_t                     result
);
    import lps_pkg::*;

    localparam int MOD_W = $clog2(TABLE_DEPTH);

    state_t         s;
    logic [MOD_W-1:0] m;
    logic [MOD_W:0] m_inc;
    logic           save;
    pattern_t       p;

    always_comb
    begin
        s = state;
        m = mod_index;
        save = 1'b0;
        m_inc = '0;
        s.tick_count = state.tick_count + 1'b1;

        if (s.tick_count == sleep_tick)
        begin
            if (s.pwm_running)
            begin
                s.saved_sd = s.sd;
                s.sd.table_sel = 1'b0;
                s.sd.value = '0;
            end
            s.saved_pattern = s.cur_pattern;
            s.cur_pattern = PAT_LOW;
            s.saved_led_levels = s.led_levels;
            s.led_levels = '0;
        end
        else if (s.tick_count == wake_tick)
        begin
            if (s.pwm_running)
            begin
                s.twinkle_index = '0;
                m = '0;
                s.sd = s.saved_sd;
            end
            s.led_levels = s.saved_led_levels;
            s.cur_pattern = s.saved_pattern;
            s.tick_count = '0;
        end

        p = s.cur_pattern;
        if (button)
        begin
            if (!s.button_latched)
            begin
                s.button_latched = 1'b1;
                case (p)
                    PAT_SOLID:
                    begin
                        s.led_levels = LEDS_ON;
                        s.cur_pattern = PAT_BLINK;
                    end
                    PAT_BLINK:
                    begin
                        s.led_levels = LEDS_A;
                        s.cur_pattern = PAT_FASTER;
                    end
                    PAT_FASTER:
                    begin
                        s.twinkle_index = '0;
                        m = '0;
                        s.pwm_running = 1'b1;
                        s.sd = '{table_sel: 1'b0, steer: STEER_BOTH, value: DUTY_FULL};
                        s.cur_pattern = PAT_TWINKLE;
                    end
                    PAT_TWINKLE:
                    begin
                        s.sd.steer = STEER_B;
                        s.led_levels[1] = 1'b0;
                        s.cur_pattern = PAT_STAR;
                    end
                    PAT_STAR:
                    begin
                        s.sd = '{table_sel: 1'b0, steer: STEER_A, value: DUTY_LIT};
                        s.led_levels[0] = 1'b1;
                        s.cur_pattern = PAT_LIT;
                    end
                    PAT_LIT:
                    begin
                        s.sd.table_sel = 1'b0;
                        s.sd.value = '0;
                        s.pwm_running = 1'b0;
                        s.cur_pattern = PAT_SOLID;
                    end
                    default:
                    begin
                    end
                endcase
                if (s.cur_pattern == PAT_LOW)
                begin
                    if (s.pwm_running)
                    begin
                        s.twinkle_index = '0;
                        m = '0;
                        s.sd = s.saved_sd;
                    end
                    s.led_levels = s.saved_led_levels;
                    s.cur_pattern = s.saved_pattern;
                    s.tick_count = '0;
                end
                else
                begin
                    save = 1'b1;
                end
            end
        end
        else
        begin
            s.button_latched = 1'b0;
            case (p) inside
                PAT_SOLID:
                begin
                    s.led_levels = LEDS_ON;
                end
                PAT_BLINK:
                begin
                    if (s.tick_count[2:0] == 3'd0)
                    begin
                        s.led_levels = ~s.led_levels;
                    end
                end
                PAT_FASTER:
                begin
                    if (s.tick_count[1:0] == 2'd0)
                    begin
                        s.led_levels = ~s.led_levels;
                    end
                end
                PAT_TWINKLE, PAT_STAR:
                begin
                    // The table position follows the index modulo the table depth.
                    m_inc = {1'b0, m} + 1'b1;
                    if (s.twinkle_index == 8'hFF)
                    begin
                        m = '0;
                    end
                    else if (m_inc == (MOD_W + 1)'(TABLE_DEPTH))
                    begin
                        m = '0;
                    end
                    else
                    begin
                        m = m_inc[MOD_W-1:0];
                    end
                    s.twinkle_index = s.twinkle_index + 1'b1;
                    s.sd.table_sel = 1'b1;
                    s.sd.value = {2'b00, 8'(m)};
                end
                default:
                begin
                end
            endcase
        end
    end

    assign state_next = s;
    assign mod_next = m;

    always_comb
    begin
        result.pattern = s.cur_pattern;
        result.led_a = s.led_levels[0];
        result.led_b = s.led_levels[1];
        result.pwm_enable = s.pwm_running && (s.cur_pattern != PAT_LOW);
        result.pwm_steer = s.sd.steer;
        result.pwm_duty = s.sd.table_sel ? 10'd0 : s.sd.value;
        result.duty_from_table = s.sd.table_sel;
        result.table_index = s.sd.table_sel ? s.sd.value[7:0] : s.twinkle_index;
        result.save_request = save;
    end

endmodule

@@ hdl/lps_result_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED pattern sequencer result register
// Holds one finished result until the receiver takes it.
// ----------------------------------------------------------------------------
module lps_result_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  lps_pkg::result_t  result,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output lps_pkg::result_t  out_result
);
    import lps_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_result = data_reg;

endmodule
